// ===== design/rufes_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// rufes_pkg: shared types for the rollback union-find edge score engine
// Operation codes, status codes, undo log kinds, controller states and the
// command/status bundles between the controller and the datapath.
// ============================================================================
package rufes_pkg;

  // Default sizes
  localparam int NUM_ELEMS_DEF  = 1024;
  localparam int LOG_DEPTH_DEF  = 4096;
  localparam int MARK_DEPTH_DEF = 1024;

  // Fixed field widths
  localparam int IN_IDX_W = 10;
  localparam int OUT_W    = 11;
  localparam int EDGE_W   = 16;
  localparam logic [EDGE_W-1:0] EDGE_MAX = '1;

  typedef enum logic [1:0] {
    MODE_MERGE    = 2'd0,
    MODE_SNAP     = 2'd1,
    MODE_ROLLBACK = 2'd2,
    MODE_QUERY    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_MARK   = 2'd1,
    ST_LOG_FULL  = 2'd2,
    ST_MARK_FULL = 2'd3
  } status_e;

  // Kind tag of an undo log word
  typedef enum logic [1:0] {
    KIND_SCORE  = 2'd0,
    KIND_PARENT = 2'd1,
    KIND_EDGE   = 2'd2
  } log_kind_e;

  typedef enum logic [2:0] {
    LOG_NONE,
    LOG_SCORE,
    LOG_PX,
    LOG_PY,
    LOG_EX
  } log_sel_e;

  typedef enum logic [1:0] {
    PW_NONE,
    PW_CLR,
    PW_ROOT,
    PW_LINK
  } par_sel_e;

  typedef enum logic [1:0] {
    EW_NONE,
    EW_CLR,
    EW_NEW
  } edge_sel_e;

  typedef enum logic [4:0] {
    S_CLR,
    S_IDLE,
    S_RED,
    S_FXR,
    S_FXC,
    S_FYR,
    S_FYC,
    S_MCHK,
    S_MCALC,
    S_MW1,
    S_MW2,
    S_MW3,
    S_SNAP,
    S_RBM,
    S_RBW,
    S_RBR,
    S_RBA,
    S_FIN
  } state_e;

  typedef struct packed {
    logic      load;
    logic      reduce;
    logic      cur_x;
    logic      cur_y;
    logic      step;
    logic      cap_x;
    logic      cap_y;
    logic      swap;
    logic      calc;
    log_sel_e  log_sel;
    par_sel_e  par_sel;
    edge_sel_e edge_sel;
    logic      clr_step;
    logic      mark_push;
    logic      cap_mark;
    logic      log_pop;
    logic      rb_apply;
    logic      mark_pop;
    logic      set_stat;
    status_e   stat_code;
    logic      finish;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  red_done;
    logic  is_root;
    logic  distinct;
    logic  log_full;
    logic  mark_full;
    logic  mark_empty;
    logic  rb_more;
    logic  clr_last;
  } stat_t;

endpackage
`default_nettype wire

// ===== design/rufes_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// rufes_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module rufes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== design/rufes_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// rufes_dp: datapath of the union-find engine
// Parent/size and edge-count memories, undo log, mark stack, root walk
// registers, score arithmetic and result registers.
// ============================================================================
module rufes_dp #(
  parameter int NUM_ELEMS  = rufes_pkg::NUM_ELEMS_DEF,
  parameter int LOG_DEPTH  = rufes_pkg::LOG_DEPTH_DEF,
  parameter int MARK_DEPTH = rufes_pkg::MARK_DEPTH_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire rufes_pkg::cmd_t                    cmd_i,
  output rufes_pkg::stat_t                        stat_o,
  input  wire logic [1:0]                         mode_i,
  input  wire logic [rufes_pkg::IN_IDX_W-1:0]     elem_x_i,
  input  wire logic [rufes_pkg::IN_IDX_W-1:0]     elem_y_i,
  output logic                                    done_o,
  output logic                                    joined_o,
  output logic [rufes_pkg::OUT_W-1:0]             score_o,
  output logic [rufes_pkg::OUT_W-1:0]             set_size_o,
  output logic                                    same_set_o,
  output logic [1:0]                              status_o
);

  localparam int EW   = $clog2(NUM_ELEMS);
  localparam int SZW  = EW + 1;
  localparam int PW   = EW + 2;
  localparam int SW   = SZW;
  localparam int OW   = (PW > rufes_pkg::EDGE_W) ? PW : rufes_pkg::EDGE_W;
  localparam int LWW  = 2 + EW + OW;
  localparam int UDW  = $clog2(LOG_DEPTH + 1);
  localparam int LIW  = $clog2(LOG_DEPTH);
  localparam int MDW  = $clog2(MARK_DEPTH + 1);
  localparam int MIW  = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
  localparam int CW   = (SZW > rufes_pkg::EDGE_W) ? SZW : rufes_pkg::EDGE_W;
  localparam int IW   = rufes_pkg::IN_IDX_W;
  localparam int EGW  = rufes_pkg::EDGE_W;

  // min(size, edges) of one set
  function automatic logic [SZW-1:0] wmin(input logic [SZW-1:0] s,
                                          input logic [EGW-1:0] e);
    logic [SZW-1:0] r;
    r = (CW'(s) < CW'(e)) ? s : SZW'(e);
    return r;
  endfunction

  // Operation registers
  rufes_pkg::mode_e        mode_q;
  logic [IW-1:0]           xr_q, yr_q;
  logic [EW-1:0]           cur_q, rx_q, ry_q;
  logic signed [PW-1:0]    pwx_q, pwy_q, npw_q;
  logic [EGW-1:0]          edx_q, edy_q, nedge_q;
  logic [SW-1:0]           score_q;
  logic [UDW-1:0]          undo_depth_q, mark_q;
  logic [MDW-1:0]          mark_depth_q;
  logic [EW-1:0]           clr_q;
  logic                    joined_q;
  rufes_pkg::status_e      status_q;
  logic                    done_q;

  // Memory ports
  logic                    par_we, edg_we, log_we;
  logic [EW-1:0]           par_waddr, edg_waddr;
  logic [PW-1:0]           par_wdata, par_rdata;
  logic [EGW-1:0]          edg_wdata, edg_rdata;
  logic [LWW-1:0]          log_wdata, log_rdata;
  logic [UDW-1:0]          depth_m1;
  logic [MDW-1:0]          mdepth_m1;
  logic [UDW-1:0]          mark_rdata;

  rufes_ram #(.WIDTH(PW), .DEPTH(NUM_ELEMS)) u_par_ram (
    .clk_i  (clk_i),
    .we_i   (par_we),
    .waddr_i(par_waddr),
    .wdata_i(par_wdata),
    .raddr_i(cur_q),
    .rdata_o(par_rdata)
  );

  rufes_ram #(.WIDTH(EGW), .DEPTH(NUM_ELEMS)) u_edge_ram (
    .clk_i  (clk_i),
    .we_i   (edg_we),
    .waddr_i(edg_waddr),
    .wdata_i(edg_wdata),
    .raddr_i(cur_q),
    .rdata_o(edg_rdata)
  );

  assign depth_m1  = undo_depth_q - UDW'(1);
  assign mdepth_m1 = mark_depth_q - MDW'(1);

  rufes_ram #(.WIDTH(LWW), .DEPTH(LOG_DEPTH)) u_log_ram (
    .clk_i  (clk_i),
    .we_i   (log_we),
    .waddr_i(undo_depth_q[LIW-1:0]),
    .wdata_i(log_wdata),
    .raddr_i(depth_m1[LIW-1:0]),
    .rdata_o(log_rdata)
  );

  rufes_ram #(.WIDTH(UDW), .DEPTH(MARK_DEPTH)) u_mark_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.mark_push),
    .waddr_i(mark_depth_q[MIW-1:0]),
    .wdata_i(undo_depth_q),
    .raddr_i(mdepth_m1[MIW-1:0]),
    .rdata_o(mark_rdata)
  );

  // Decoded log word being rolled back
  rufes_pkg::log_kind_e    rb_kind;
  logic [EW-1:0]           rb_addr;
  logic [OW-1:0]           rb_old;

  assign rb_kind = rufes_pkg::log_kind_e'(log_rdata[LWW-1 -: 2]);
  assign rb_addr = log_rdata[OW +: EW];
  assign rb_old  = log_rdata[OW-1:0];

  // Set sizes and score arithmetic
  logic [SZW-1:0]          sx, sy, wx, wy, wnew;
  logic [EGW-1:0]          einc, esum;
  logic [EGW+1:0]          sum_w;
  logic                    distinct;
  logic [SW-1:0]           score_new;

  assign distinct = (rx_q != ry_q);
  assign sx       = SZW'(-pwx_q);
  assign sy       = SZW'(-pwy_q);
  assign wx       = wmin(sx, edx_q);
  assign wy       = wmin(sy, edy_q);
  assign einc     = (edx_q == rufes_pkg::EDGE_MAX) ? edx_q : edx_q + EGW'(1);
  assign sum_w    = (EGW+2)'(edx_q) + (EGW+2)'(edy_q) + (EGW+2)'(1);
  assign esum     = (sum_w > (EGW+2)'(rufes_pkg::EDGE_MAX)) ? rufes_pkg::EDGE_MAX
                                                           : sum_w[EGW-1:0];

  always_comb begin
    if (distinct) begin
      wnew      = wmin(sx + sy, esum);
      score_new = score_q - wx - wy + wnew;
    end else begin
      wnew      = wmin(sx, einc);
      score_new = score_q - wx + wnew;
    end
  end

  // Status toward the controller
  logic [UDW-1:0] log_free;

  assign log_free = UDW'(LOG_DEPTH) - undo_depth_q;

  always_comb begin
    stat_o.mode       = mode_q;
    stat_o.red_done   = (32'(xr_q) < 32'(NUM_ELEMS)) && (32'(yr_q) < 32'(NUM_ELEMS));
    stat_o.is_root    = par_rdata[PW-1];
    stat_o.distinct   = distinct;
    stat_o.log_full   = log_free < (distinct ? UDW'(4) : UDW'(2));
    stat_o.mark_full  = mark_depth_q >= MDW'(MARK_DEPTH);
    stat_o.mark_empty = (mark_depth_q == '0);
    stat_o.rb_more    = undo_depth_q > mark_q;
    stat_o.clr_last   = (clr_q == EW'(NUM_ELEMS - 1));
  end

  // Undo log write data
  always_comb begin
    log_we    = 1'b1;
    log_wdata = {rufes_pkg::KIND_SCORE, EW'(0), OW'(score_q)};
    case (cmd_i.log_sel)
      rufes_pkg::LOG_SCORE: log_wdata = {rufes_pkg::KIND_SCORE, EW'(0), OW'(score_q)};
      rufes_pkg::LOG_PX:    log_wdata = {rufes_pkg::KIND_PARENT, rx_q, OW'(pwx_q)};
      rufes_pkg::LOG_PY:    log_wdata = {rufes_pkg::KIND_PARENT, ry_q, OW'(pwy_q)};
      rufes_pkg::LOG_EX:    log_wdata = {rufes_pkg::KIND_EDGE, rx_q, OW'(edx_q)};
      default:              log_we    = 1'b0;
    endcase
  end

  // Parent/size memory write port
  always_comb begin
    par_we    = 1'b0;
    par_waddr = rx_q;
    par_wdata = npw_q;
    if (cmd_i.rb_apply && rb_kind == rufes_pkg::KIND_PARENT) begin
      par_we    = 1'b1;
      par_waddr = rb_addr;
      par_wdata = rb_old[PW-1:0];
    end
    case (cmd_i.par_sel)
      rufes_pkg::PW_CLR: begin
        par_we    = 1'b1;
        par_waddr = clr_q;
        par_wdata = '1;
      end
      rufes_pkg::PW_ROOT: begin
        par_we    = 1'b1;
        par_waddr = rx_q;
        par_wdata = npw_q;
      end
      rufes_pkg::PW_LINK: begin
        par_we    = 1'b1;
        par_waddr = ry_q;
        par_wdata = PW'(rx_q);
      end
      default: ;
    endcase
  end

  // Edge count memory write port
  always_comb begin
    edg_we    = 1'b0;
    edg_waddr = rx_q;
    edg_wdata = nedge_q;
    if (cmd_i.rb_apply && rb_kind != rufes_pkg::KIND_SCORE &&
        rb_kind != rufes_pkg::KIND_PARENT) begin
      edg_we    = 1'b1;
      edg_waddr = rb_addr;
      edg_wdata = rb_old[EGW-1:0];
    end
    case (cmd_i.edge_sel)
      rufes_pkg::EW_CLR: begin
        edg_we    = 1'b1;
        edg_waddr = clr_q;
        edg_wdata = '0;
      end
      rufes_pkg::EW_NEW: begin
        edg_we    = 1'b1;
        edg_waddr = rx_q;
        edg_wdata = nedge_q;
      end
      default: ;
    endcase
  end

  // Operand capture, index reduction and root walk
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q   <= rufes_pkg::mode_e'(mode_i);
      xr_q     <= elem_x_i;
      yr_q     <= elem_y_i;
      joined_q <= 1'b0;
      status_q <= rufes_pkg::ST_OK;
    end
    if (cmd_i.reduce) begin
      if (32'(xr_q) >= 32'(NUM_ELEMS)) xr_q <= xr_q - IW'(NUM_ELEMS);
      if (32'(yr_q) >= 32'(NUM_ELEMS)) yr_q <= yr_q - IW'(NUM_ELEMS);
    end
    if (cmd_i.cur_x) cur_q <= EW'(xr_q);
    if (cmd_i.cur_y) cur_q <= EW'(yr_q);
    if (cmd_i.step)  cur_q <= par_rdata[EW-1:0];
    if (cmd_i.cap_x) begin
      rx_q  <= cur_q;
      pwx_q <= par_rdata;
      edx_q <= edg_rdata;
    end
    if (cmd_i.cap_y) begin
      ry_q  <= cur_q;
      pwy_q <= par_rdata;
      edy_q <= edg_rdata;
    end
    // larger set (more negative word) becomes the new root
    if (cmd_i.swap && (pwx_q > pwy_q)) begin
      rx_q  <= ry_q;
      ry_q  <= rx_q;
      pwx_q <= pwy_q;
      pwy_q <= pwx_q;
      edx_q <= edy_q;
      edy_q <= edx_q;
    end
    if (cmd_i.calc) begin
      nedge_q  <= distinct ? esum : einc;
      npw_q    <= pwx_q + pwy_q;
      joined_q <= distinct;
    end
    if (cmd_i.cap_mark) mark_q <= mark_rdata;
    if (cmd_i.set_stat) status_q <= cmd_i.stat_code;
  end

  // Score, depths and clear counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_q      <= '0;
      undo_depth_q <= '0;
      mark_depth_q <= '0;
      clr_q        <= '0;
    end else begin
      if (cmd_i.calc) score_q <= score_new;
      if (cmd_i.rb_apply && rb_kind == rufes_pkg::KIND_SCORE) score_q <= rb_old[SW-1:0];
      if (log_we)           undo_depth_q <= undo_depth_q + UDW'(1);
      if (cmd_i.log_pop)    undo_depth_q <= depth_m1;
      if (cmd_i.mark_push)  mark_depth_q <= mark_depth_q + MDW'(1);
      if (cmd_i.mark_pop)   mark_depth_q <= mdepth_m1;
      if (cmd_i.clr_step)   clr_q <= clr_q + EW'(1);
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      joined_o   <= joined_q;
      score_o    <= rufes_pkg::OUT_W'(score_q);
      set_size_o <= (mode_q == rufes_pkg::MODE_QUERY) ? rufes_pkg::OUT_W'(sx) : '0;
      same_set_o <= (mode_q == rufes_pkg::MODE_QUERY) && !distinct;
      status_o   <= status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
    end
  end

  assign done_o = done_q;

  // Checks
  a_log_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    undo_depth_q <= UDW'(LOG_DEPTH)) else $error("undo depth beyond log size");
  a_mark_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mark_depth_q <= MDW'(MARK_DEPTH)) else $error("mark depth beyond stack size");
  a_score_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(score_q) <= 32'(NUM_ELEMS)) else $error("score above element count");
  a_log_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    log_we |-> undo_depth_q < UDW'(LOG_DEPTH)) else $error("log push while full");

endmodule
`default_nettype wire

// ===== design/rufes_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// rufes_ctrl: controller of the union-find engine
// Sequences the clearing pass, root walks, merge log/write steps, snapshot
// and rollback replay; drives datapath commands.
// ============================================================================
module rufes_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire rufes_pkg::stat_t stat_i,
  output logic                  busy_o,
  output rufes_pkg::cmd_t       cmd_o
);

  rufes_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rufes_pkg::S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != rufes_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      // fill parent words with -1 and edge counts with zero
      rufes_pkg::S_CLR: begin
        cmd_o.par_sel  = rufes_pkg::PW_CLR;
        cmd_o.edge_sel = rufes_pkg::EW_CLR;
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) state_d = rufes_pkg::S_IDLE;
      end
      rufes_pkg::S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = rufes_pkg::S_RED;
        end
      end
      // fold indices into range, then dispatch
      rufes_pkg::S_RED: begin
        if (!stat_i.red_done) begin
          cmd_o.reduce = 1'b1;
        end else begin
          case (stat_i.mode)
            rufes_pkg::MODE_SNAP:     state_d = rufes_pkg::S_SNAP;
            rufes_pkg::MODE_ROLLBACK: state_d = rufes_pkg::S_RBM;
            default: begin
              cmd_o.cur_x = 1'b1;
              state_d     = rufes_pkg::S_FXR;
            end
          endcase
        end
      end
      // root walk of x: read, then check
      rufes_pkg::S_FXR: state_d = rufes_pkg::S_FXC;
      rufes_pkg::S_FXC: begin
        if (stat_i.is_root) begin
          cmd_o.cap_x = 1'b1;
          cmd_o.cur_y = 1'b1;
          state_d     = rufes_pkg::S_FYR;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = rufes_pkg::S_FXR;
        end
      end
      rufes_pkg::S_FYR: state_d = rufes_pkg::S_FYC;
      rufes_pkg::S_FYC: begin
        if (stat_i.is_root) begin
          cmd_o.cap_y = 1'b1;
          state_d     = (stat_i.mode == rufes_pkg::MODE_QUERY) ? rufes_pkg::S_FIN
                                                              : rufes_pkg::S_MCHK;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = rufes_pkg::S_FYR;
        end
      end
      // merge: room check and root ordering
      rufes_pkg::S_MCHK: begin
        if (stat_i.log_full) begin
          cmd_o.set_stat  = 1'b1;
          cmd_o.stat_code = rufes_pkg::ST_LOG_FULL;
          state_d         = rufes_pkg::S_FIN;
        end else begin
          cmd_o.swap = stat_i.distinct;
          state_d    = rufes_pkg::S_MCALC;
        end
      end
      rufes_pkg::S_MCALC: begin
        cmd_o.calc    = 1'b1;
        cmd_o.log_sel = rufes_pkg::LOG_SCORE;
        state_d       = rufes_pkg::S_MW1;
      end
      rufes_pkg::S_MW1: begin
        if (stat_i.distinct) begin
          cmd_o.log_sel = rufes_pkg::LOG_PX;
          cmd_o.par_sel = rufes_pkg::PW_ROOT;
          state_d       = rufes_pkg::S_MW2;
        end else begin
          cmd_o.log_sel  = rufes_pkg::LOG_EX;
          cmd_o.edge_sel = rufes_pkg::EW_NEW;
          state_d        = rufes_pkg::S_FIN;
        end
      end
      rufes_pkg::S_MW2: begin
        cmd_o.log_sel = rufes_pkg::LOG_PY;
        cmd_o.par_sel = rufes_pkg::PW_LINK;
        state_d       = rufes_pkg::S_MW3;
      end
      rufes_pkg::S_MW3: begin
        cmd_o.log_sel  = rufes_pkg::LOG_EX;
        cmd_o.edge_sel = rufes_pkg::EW_NEW;
        state_d        = rufes_pkg::S_FIN;
      end
      rufes_pkg::S_SNAP: begin
        if (stat_i.mark_full) begin
          cmd_o.set_stat  = 1'b1;
          cmd_o.stat_code = rufes_pkg::ST_MARK_FULL;
        end else begin
          cmd_o.mark_push = 1'b1;
        end
        state_d = rufes_pkg::S_FIN;
      end
      // rollback: fetch top mark, then replay log words newest first
      rufes_pkg::S_RBM: begin
        if (stat_i.mark_empty) begin
          cmd_o.set_stat  = 1'b1;
          cmd_o.stat_code = rufes_pkg::ST_NO_MARK;
          state_d         = rufes_pkg::S_FIN;
        end else begin
          state_d = rufes_pkg::S_RBW;
        end
      end
      rufes_pkg::S_RBW: begin
        cmd_o.cap_mark = 1'b1;
        state_d        = rufes_pkg::S_RBR;
      end
      rufes_pkg::S_RBR: begin
        if (stat_i.rb_more) begin
          cmd_o.log_pop = 1'b1;
          state_d       = rufes_pkg::S_RBA;
        end else begin
          cmd_o.mark_pop = 1'b1;
          state_d        = rufes_pkg::S_FIN;
        end
      end
      rufes_pkg::S_RBA: begin
        cmd_o.rb_apply = 1'b1;
        state_d        = rufes_pkg::S_RBR;
      end
      rufes_pkg::S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = rufes_pkg::S_IDLE;
      end
      default: state_d = rufes_pkg::S_IDLE;
    endcase
  end

  // Checks
  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rufes_pkg::S_FIN |=> state_q == rufes_pkg::S_IDLE)
    else $error("finish not followed by idle");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> !busy_o) else $error("load while busy");
  a_one_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.log_pop, cmd_o.rb_apply, cmd_o.mark_pop}) <= 1)
    else $error("overlapping rollback commands");

endmodule
`default_nettype wire

// ===== design/rollback_union_find_edge_score_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// rollback_union_find_edge_score_top: rollback disjoint-set engine
// Union by size with undo log, snapshot/rollback and a min(size,edges) score.
// ============================================================================
// Usage:
//   Issue a transaction by raising start_i with mode_i, elem_x_i, elem_y_i;
//   it is taken on a clock edge where busy_o is low. Exactly one result
//   follows: done_o is high for one cycle with joined_o, score_o,
//   set_size_o, same_set_o and status_o valid. The receiver cannot stall;
//   a result must be taken in that cycle.
//   A snapshot pushes a mark. A query walks x, then y, to its root; the root
//   walk depths are at most log2 NUM_ELEMS, one parent memory read per step.
//   A merge logs and writes more steps when it links two sets than when both
//   roots match, and stops without writing when the log lacks room; a rollback
//   takes a step per undone log word, and ends without replay when no mark is
//   open.
//   Indices at or above NUM_ELEMS are folded in one subtract per cycle.
//   One transaction is in flight at a time; busy_o falls as done_o rises.
//   Reset: after rst_ni is released, a clearing pass writes every entry of
//   the parent and edge memories, one entry per cycle, while busy_o stays
//   high; depths and score start at zero.
// ============================================================================
module rollback_union_find_edge_score_top #(
  parameter int NUM_ELEMS  = rufes_pkg::NUM_ELEMS_DEF,
  parameter int LOG_DEPTH  = rufes_pkg::LOG_DEPTH_DEF,
  parameter int MARK_DEPTH = rufes_pkg::MARK_DEPTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire logic [1:0]                     mode_i,
  input  wire logic [rufes_pkg::IN_IDX_W-1:0] elem_x_i,
  input  wire logic [rufes_pkg::IN_IDX_W-1:0] elem_y_i,
  output logic                                done_o,
  output logic                                joined_o,
  output logic [rufes_pkg::OUT_W-1:0]         score_o,
  output logic [rufes_pkg::OUT_W-1:0]         set_size_o,
  output logic                                same_set_o,
  output logic [1:0]                          status_o
);

  rufes_pkg::cmd_t  cmd;
  rufes_pkg::stat_t stat;

  rufes_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .busy_o (busy_o),
    .cmd_o  (cmd)
  );

  rufes_dp #(
    .NUM_ELEMS (NUM_ELEMS),
    .LOG_DEPTH (LOG_DEPTH),
    .MARK_DEPTH(MARK_DEPTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .mode_i    (mode_i),
    .elem_x_i  (elem_x_i),
    .elem_y_i  (elem_y_i),
    .done_o    (done_o),
    .joined_o  (joined_o),
    .score_o   (score_o),
    .set_size_o(set_size_o),
    .same_set_o(same_set_o),
    .status_o  (status_o)
  );

endmodule
`default_nettype wire
